// ===== rtl/packet_crc32_append_or_check_assert.svh =====
// Assertion macros for the packet CRC-32 append/check block.
`ifndef PACKET_CRC32_APPEND_OR_CHECK_ASSERT_SVH
`define PACKET_CRC32_APPEND_OR_CHECK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCRC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCRC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pcrc_pkg.sv =====
// Shared types, constants and the byte-wise CRC-32 update for the CRC block.
package pcrc_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CrcW      = 32;
  localparam int unsigned CntW      = 32;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned LineDepth = 32;
  localparam int unsigned LineIdxW  = $clog2(LineDepth);
  localparam int unsigned FillW     = LineIdxW + 1;

  localparam logic [CrcW-1:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [CrcW-1:0] CrcInit = 32'hFFFF_FFFF;

  // trailer lengths, and the index of the last trailer item
  localparam logic [FillW-1:0]    TrlLenPacked    = FillW'(4);
  localparam logic [FillW-1:0]    TrlLenUnpacked  = FillW'(32);
  localparam logic [LineIdxW-1:0] TrlLastPacked   = LineIdxW'(3);
  localparam logic [LineIdxW-1:0] TrlLastUnpacked = LineIdxW'(31);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCheckMode  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgPackedMode = CfgIdxW'(1);

  // control from the core to the trailer delay line
  typedef struct packed {
    logic                load;
    logic                shift;
    logic                packed_mode;
    logic [LineIdxW-1:0] wr_idx;
    logic [ByteW-1:0]    data;
  } pcrc_dl_ctl_t;

  function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] acc_in,
                                               input logic [ByteW-1:0] data);
    logic [CrcW-1:0] acc;
    acc = acc_in ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int b = 0; b < ByteW; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

// ===== rtl/pcrc_in_stage.sv =====
// Input register stage: holds one beat until the core takes it.
module pcrc_in_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [pcrc_pkg::ByteW-1:0] byte_i,
  input  logic                      last_i,
  output logic                      valid_o,
  input  logic                      take_i,
  output logic [pcrc_pkg::ByteW-1:0] byte_o,
  output logic                      last_o
);
  import pcrc_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             last_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

// ===== rtl/pcrc_delay_line.sv =====
// Trailer delay line: fills by index, then shifts; compares against a CRC.
module pcrc_delay_line (
  input  logic                        clk_i,
  input  pcrc_pkg::pcrc_dl_ctl_t      ctl_i,
  input  logic [pcrc_pkg::CrcW-1:0]   crc_i,
  output logic [pcrc_pkg::ByteW-1:0]  head_o,
  output logic                        match_o
);
  import pcrc_pkg::*;

  logic [ByteW-1:0]    line_q [LineDepth];
  logic [ByteW-1:0]    line_d [LineDepth];
  logic [LineIdxW-1:0] last_idx;
  logic                match_packed, match_unpacked;

  assign last_idx = ctl_i.packed_mode ? TrlLastPacked : TrlLastUnpacked;
  assign head_o   = line_q[0];

  always_comb begin
    line_d = line_q;
    if (ctl_i.load) begin
      line_d[ctl_i.wr_idx] = ctl_i.data;
    end else if (ctl_i.shift) begin
      for (int i = 0; i < LineDepth - 1; i++) begin
        if (LineIdxW'(i) < last_idx) begin
          line_d[i] = line_q[i+1];
        end
      end
      line_d[last_idx] = ctl_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
  end

  // verdict is taken on the line as it stands after this beat
  always_comb begin
    match_packed = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (line_d[k] != crc_i[8*k +: 8]) begin
        match_packed = 1'b0;
      end
    end
    match_unpacked = 1'b1;
    for (int k = 0; k < LineDepth; k++) begin
      if (line_d[k] != {{(ByteW-1){1'b0}}, crc_i[k]}) begin
        match_unpacked = 1'b0;
      end
    end
  end

  assign match_o = ctl_i.packed_mode ? match_packed : match_unpacked;

endmodule

// ===== rtl/packet_crc32_append_or_check.sv =====
// An accepted input beat passes the input register, then the result register; 1 beat per cycle
// is sustained while the output is ready and no trailer is sent. In append mode the last beat
// is followed by 4 (packed) or 32 (unpacked) CRC beats from the trailer sequencer, during which
// input is held off. Check mode emits at most one result per input beat.
// Reset (async, active low): append mode, packed trailer, CRC all ones, counters and fill cleared.
module packet_crc32_append_or_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,   // in_byte
  input  logic                           s_axis_tlast_i,   // in_last
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [71:0]                    m_axis_tdata_o,   // out_byte, pass_total, fail_total
  output logic                           m_axis_tlast_o,   // out_last
  output logic [1:0]                     m_axis_tuser_o,   // is_crc_item, frame_ok
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pcrc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic                           cfg_data_i
);
  `include "packet_crc32_append_or_check_assert.svh"
  import pcrc_pkg::*;

  logic             in_valid, in_last, adv;
  logic [ByteW-1:0] in_byte;

  logic                check_q, packed_q;
  logic [CrcW-1:0]     crc_q, crc_d, crc_fin_q, crc_app, crc_chk;
  logic [FillW-1:0]    fill_q, fill_d, fill_next, trl_len;
  logic [CntW-1:0]     pass_q, pass_d, fail_q, fail_d;
  logic                trl_busy_q;
  logic [LineIdxW-1:0] trl_idx_q, trl_last;

  logic             m_valid_q;
  logic [ByteW-1:0] o_byte_q;
  logic             o_last_q, o_crc_q, o_ok_q;
  logic [CntW-1:0]  o_pass_q, o_fail_q;

  logic             out_free, trl_emit, full, emit_res, ok, match, cfg_wr;
  logic [ByteW-1:0] head, trl_item;
  pcrc_dl_ctl_t     dl_ctl;

  pcrc_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .byte_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .valid_o (in_valid),
    .take_i  (adv),
    .byte_o  (in_byte),
    .last_o  (in_last)
  );

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign adv      = in_valid && out_free && !trl_busy_q;
  assign trl_emit = trl_busy_q && out_free;
  assign trl_len  = packed_q ? TrlLenPacked : TrlLenUnpacked;
  assign trl_last = packed_q ? TrlLastPacked : TrlLastUnpacked;

  assign cfg_ready_o = !in_valid && !trl_busy_q && !m_valid_q;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // check mode: oldest held beat leaves the line once it is full
  assign full      = (fill_q == trl_len);
  assign fill_next = full ? trl_len : fill_q + FillW'(1);
  assign crc_app   = crc_feed(crc_q, in_byte);
  assign crc_chk   = full ? crc_feed(crc_q, head) : crc_q;

  always_comb begin
    dl_ctl.load        = adv && check_q && !full;
    dl_ctl.shift       = adv && check_q && full;
    dl_ctl.packed_mode = packed_q;
    dl_ctl.wr_idx      = fill_q[LineIdxW-1:0];
    dl_ctl.data        = in_byte;
  end

  pcrc_delay_line u_line (
    .clk_i   (clk_i),
    .ctl_i   (dl_ctl),
    .crc_i   (~crc_chk),
    .head_o  (head),
    .match_o (match)
  );

  assign ok = (fill_next == trl_len) && match;

  assign trl_item = packed_q ? crc_fin_q[8*trl_idx_q[1:0] +: 8]
                             : {{(ByteW-1){1'b0}}, crc_fin_q[trl_idx_q]};

  always_comb begin
    crc_d  = crc_q;
    fill_d = fill_q;
    pass_d = pass_q;
    fail_d = fail_q;
    emit_res = 1'b0;
    if (adv) begin
      if (!check_q) begin
        emit_res = 1'b1;
        crc_d    = in_last ? CrcInit : crc_app;
        fill_d   = in_last ? '0 : fill_q;
      end else begin
        emit_res = full || in_last;
        if (in_last) begin
          crc_d  = CrcInit;
          fill_d = '0;
          if (ok) begin
            pass_d = pass_q + CntW'(1);
          end else begin
            fail_d = fail_q + CntW'(1);
          end
        end else begin
          crc_d  = crc_chk;
          fill_d = fill_next;
        end
      end
    end
    if (cfg_wr && (cfg_index_i == CfgCheckMode || cfg_index_i == CfgPackedMode)) begin
      crc_d  = CrcInit;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_q    <= 1'b0;
      packed_q   <= 1'b1;
      crc_q      <= CrcInit;
      fill_q     <= '0;
      pass_q     <= '0;
      fail_q     <= '0;
      trl_busy_q <= 1'b0;
      trl_idx_q  <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      fill_q <= fill_d;
      pass_q <= pass_d;
      fail_q <= fail_d;
      if (cfg_wr) begin
        case (cfg_index_i)
          CfgCheckMode:  check_q  <= cfg_data_i;
          CfgPackedMode: packed_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (trl_emit) begin
        trl_idx_q <= trl_idx_q + LineIdxW'(1);
        if (trl_idx_q == trl_last) begin
          trl_busy_q <= 1'b0;
        end
      end else if (adv && !check_q && in_last) begin
        trl_busy_q <= 1'b1;
        trl_idx_q  <= '0;
      end
      if (trl_emit || emit_res) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // result register and the latched CRC for the append trailer
  always_ff @(posedge clk_i) begin
    if (adv && !check_q && in_last) begin
      crc_fin_q <= ~crc_app;
    end
    if (trl_emit) begin
      o_byte_q <= trl_item;
      o_last_q <= (trl_idx_q == trl_last);
      o_crc_q  <= 1'b1;
      o_ok_q   <= 1'b0;
      o_pass_q <= pass_q;
      o_fail_q <= fail_q;
    end else if (emit_res) begin
      o_byte_q <= (check_q && !full) ? '0 : (check_q ? head : in_byte);
      o_last_q <= check_q && in_last;
      o_crc_q  <= 1'b0;
      o_ok_q   <= check_q && in_last && ok;
      o_pass_q <= pass_d;
      o_fail_q <= fail_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {o_fail_q, o_pass_q, o_byte_q};
  assign m_axis_tlast_o  = o_last_q;
  assign m_axis_tuser_o  = {o_ok_q, o_crc_q};

  `PCRC_ASSERT_NOW(a_no_take_in_trailer, clk_i, rst_ni, trl_busy_q, !adv,
                   "input beat taken during CRC trailer")
  `PCRC_ASSERT_NOW(a_ok_on_last, clk_i, rst_ni, m_valid_q && o_ok_q, o_last_q,
                   "frame_ok set on a beat that is not last")
  `PCRC_ASSERT_NOW(a_no_trailer_in_check, clk_i, rst_ni, m_valid_q && check_q, !o_crc_q,
                   "CRC item emitted in check mode")
  `PCRC_ASSERT_NEXT(a_append_counts_fixed, clk_i, rst_ni, adv && !check_q,
                    pass_q == $past(pass_q) && fail_q == $past(fail_q),
                    "counters changed in append mode")

endmodule
